/* hdl/lpm_pkg.sv */
package lpm_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned SCAN_N      = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH
                                                                     : (1 << IDX_W);
  localparam int unsigned SCAN_W      = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int unsigned ROUTE_W     = 64;

  typedef enum logic [0:0] {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [31:0]       entry_dest;
    logic [31:0]       entry_mask;
    logic              entry_valid;
    logic [31:0]       lookup_addr;
  } lpm_req_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  match_index;
    logic [31:0]       match_mask;
  } lpm_rsp_t;

  typedef struct packed {
    logic              clear;
    logic              cmp_en;
    logic [SCAN_W-1:0] cmp_idx;
  } scan_ctl_t;

endpackage

/* hdl/longest_prefix_match_lookup.sv */
// IPv4 longest-prefix-match route table. A transaction is taken when start is high and busy
// is low. A write transaction stores one route and gives no result; slots at or beyond the
// table depth are ignored. A lookup transaction reads the route memory one entry per cycle
// through its single read port and keeps the best match; it holds busy through the scan of
// the table entries, the ST_LAST state, in which the registered read of the last entry is
// compared, and the result state. The result is shown for exactly one cycle with rsp_valid_o
// high and cannot be held off, so the receiver must take it in that cycle. The valid marks
// are cleared by reset.
module longest_prefix_match_lookup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  lpm_pkg::lpm_req_t  req_i,
  output logic               rsp_valid_o,
  output lpm_pkg::lpm_rsp_t  rsp_o
);

  logic                         accept_w;
  logic                         lookup_go_w;
  logic                         wr_go_w;
  logic                         rd_en_w;
  logic [lpm_pkg::ADDR_W-1:0]   rd_addr_w;
  logic [lpm_pkg::ROUTE_W-1:0]  route_w;
  logic [lpm_pkg::SCAN_N-1:0]   valid_q, valid_d;
  lpm_pkg::scan_ctl_t           ctl_w;

  assign accept_w    = start && !busy;
  assign lookup_go_w = accept_w && (req_i.req_type == lpm_pkg::REQ_LOOKUP);
  assign wr_go_w     = accept_w && (req_i.req_type == lpm_pkg::REQ_WRITE)
                       && (32'(req_i.entry_index) < lpm_pkg::TABLE_DEPTH);

  always_comb begin
    valid_d = valid_q;
    if (wr_go_w) begin
      valid_d[lpm_pkg::SCAN_W'(req_i.entry_index)] = req_i.entry_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  lpm_ram #(
    .WIDTH (lpm_pkg::ROUTE_W),
    .DEPTH (lpm_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_go_w),
    .waddr_i (lpm_pkg::ADDR_W'(req_i.entry_index)),
    .wdata_i ({req_i.entry_dest, req_i.entry_mask}),
    .re_i    (rd_en_w),
    .raddr_i (rd_addr_w),
    .rdata_o (route_w)
  );

  lpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_go_i (lookup_go_w),
    .busy_o      (busy),
    .rd_en_o     (rd_en_w),
    .rd_addr_o   (rd_addr_w),
    .rsp_valid_o (rsp_valid_o),
    .ctl_o       (ctl_w)
  );

  lpm_select u_select (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_w),
    .lookup_addr_i (req_i.lookup_addr),
    .entry_valid_i (valid_q[ctl_w.cmp_idx]),
    .route_i       (route_w),
    .rsp_o         (rsp_o)
  );

endmodule

/* hdl/lpm_ram.sv */
module lpm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lpm_ctrl.sv */
module lpm_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           lookup_go_i,
  output logic                           busy_o,
  output logic                           rd_en_o,
  output logic [lpm_pkg::ADDR_W-1:0]     rd_addr_o,
  output logic                           rsp_valid_o,
  output lpm_pkg::scan_ctl_t             ctl_o
);

  lpm_pkg::state_e             state_q, state_d;
  logic [lpm_pkg::SCAN_W-1:0]  cnt_q, cnt_d;
  logic                        cmp_en_q;
  logic [lpm_pkg::SCAN_W-1:0]  cmp_idx_q;
  logic                        last_w;

  assign last_w = (cnt_q == lpm_pkg::SCAN_W'(lpm_pkg::SCAN_N - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpm_pkg::ST_IDLE: begin
        if (lookup_go_i) begin
          state_d = lpm_pkg::ST_SCAN;
        end
      end
      lpm_pkg::ST_SCAN: begin
        if (last_w) begin
          state_d = lpm_pkg::ST_LAST;
        end
      end
      lpm_pkg::ST_LAST:   state_d = lpm_pkg::ST_RESULT;
      lpm_pkg::ST_RESULT: state_d = lpm_pkg::ST_IDLE;
      default:            state_d = lpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o      = (state_q != lpm_pkg::ST_IDLE);
    rd_en_o     = (state_q == lpm_pkg::ST_SCAN);
    rsp_valid_o = (state_q == lpm_pkg::ST_RESULT);
    rd_addr_o   = lpm_pkg::ADDR_W'(cnt_q);
    cnt_d       = '0;
    if ((state_q == lpm_pkg::ST_SCAN) && !last_w) begin
      cnt_d = cnt_q + 1'b1;
    end
    ctl_o.clear   = lookup_go_i;
    ctl_o.cmp_en  = cmp_en_q;
    ctl_o.cmp_idx = cmp_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lpm_pkg::ST_IDLE;
      cnt_q     <= '0;
      cmp_en_q  <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_en_q  <= (state_q == lpm_pkg::ST_SCAN);
      cmp_idx_q <= cnt_q;
    end
  end

endmodule

/* hdl/lpm_select.sv */
module lpm_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpm_pkg::scan_ctl_t           ctl_i,
  input  logic [31:0]                  lookup_addr_i,
  input  logic                         entry_valid_i,
  input  logic [lpm_pkg::ROUTE_W-1:0]  route_i,
  output lpm_pkg::lpm_rsp_t            rsp_o
);

  logic                       found_q, found_d;
  logic [lpm_pkg::IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [31:0]                best_mask_q, best_mask_d;
  logic [31:0]                addr_q, addr_d;
  logic [31:0]                dest_w, mask_w;
  logic                       match_w;

  assign dest_w  = route_i[63:32];
  assign mask_w  = route_i[31:0];
  assign match_w = ctl_i.cmp_en && entry_valid_i && (((dest_w ^ addr_q) & mask_w) == 32'd0);

  always_comb begin
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_mask_d = best_mask_q;
    addr_d      = addr_q;
    if (ctl_i.clear) begin
      found_d     = 1'b0;
      best_idx_d  = '0;
      best_mask_d = '0;
      addr_d      = lookup_addr_i;
    end else if (match_w && (!found_q || (mask_w > best_mask_q))) begin
      found_d     = 1'b1;
      best_idx_d  = lpm_pkg::IDX_W'(ctl_i.cmp_idx);
      best_mask_d = mask_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_mask_q <= best_mask_d;
    addr_q      <= addr_d;
  end

  assign rsp_o.hit         = found_q;
  assign rsp_o.match_index = best_idx_q;
  assign rsp_o.match_mask  = best_mask_q;

endmodule

/* hdl/lpm_chk.sv */
module lpm_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input lpm_pkg::lpm_req_t  req_i,
  input logic               rsp_valid_o,
  input lpm_pkg::lpm_rsp_t  rsp_o
);

  // A result is only ever produced at the end of a lookup.
  a_rsp_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy)
    else $error("result strobe outside a lookup");

  // A result strobe lasts one cycle and frees the block for the next transaction.
  a_rsp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> (!rsp_valid_o && !busy))
    else $error("result strobe not followed by idle");

  // An accepted lookup holds the block busy.
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.req_type == lpm_pkg::REQ_LOOKUP)) |=> busy)
    else $error("lookup accepted without going busy");

  // A write transaction never blocks the next one.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.req_type == lpm_pkg::REQ_WRITE)) |=> !busy)
    else $error("write transaction left the block busy");

  // A miss reports a zero slot and a zero mask.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_o.hit) |-> ((rsp_o.match_index == '0) && (rsp_o.match_mask == '0)))
    else $error("miss with non-zero slot or mask");

endmodule

bind longest_prefix_match_lookup lpm_chk u_lpm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
